>>> hw/rtl/iirs_pkg.sv
// ----------------------------------------------------------------------------
// iirs_pkg
// Shared types and constants of the summed-area table box-sum core: the item
// formats of both channels, command, status and register codes, and the
// controller states.
// ----------------------------------------------------------------------------
package iirs_pkg;

   localparam int PIXEL_W     = 8;
   localparam int RECT_X_W    = 9;
   localparam int RECT_Y_W    = 8;
   localparam int RECT_W_W    = 10;
   localparam int RECT_H_W    = 9;
   localparam int SUM_W       = 25;
   localparam int STATUS_W    = 2;
   localparam int RSUM_W      = 17;
   localparam int IMG_W_W     = 10;
   localparam int IMG_H_W     = 9;
   localparam int CSR_DATA_W  = 10;
   localparam int CSR_INDEX_W = 1;

   // Horizontal and vertical far edge of a rectangle (x + w, y + h)
   localparam int EDGE_X_W = RECT_W_W + 1;
   localparam int EDGE_Y_W = RECT_H_W + 1;

   localparam logic [IMG_W_W-1:0] IMG_WIDTH_RST  = 10'd512;
   localparam logic [IMG_H_W-1:0] IMG_HEIGHT_RST = 9'd256;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMG_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMG_HEIGHT = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BOUNDS    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_READY = 2'd2;

   typedef struct packed {
      logic                cmd;
      logic                first_pixel;
      logic [PIXEL_W-1:0]  pixel;
      logic [RECT_X_W-1:0] rect_x;
      logic [RECT_Y_W-1:0] rect_y;
      logic [RECT_W_W-1:0] rect_w;
      logic [RECT_H_W-1:0] rect_h;
   } req_type;

   typedef struct packed {
      logic [SUM_W-1:0]    rect_sum;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_LOAD_WR  = 4'b0010,
      ST_QRY_RD2  = 4'b0100,
      ST_QRY_FIN  = 4'b1000
   } state_type;

endpackage

>>> hw/rtl/iirs_ram.sv
// ----------------------------------------------------------------------------
// iirs_ram
// Generic single-write, single-read synchronous RAM. Read data is registered
// and holds while the read enable is low.
// ----------------------------------------------------------------------------
module iirs_ram #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 131072,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/iirs_scan.sv
// ----------------------------------------------------------------------------
// iirs_scan
// Raster position tracker of the table build: image size registers, column
// and row position, running row sum and the image-complete flag. Gives the
// table addresses and row sum for the load item on the request port.
// ----------------------------------------------------------------------------
module iirs_scan import iirs_pkg::*; #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 256,
   parameter int COL_W      = $clog2(MAX_WIDTH),
   parameter int ROW_W      = $clog2(MAX_HEIGHT),
   parameter int EW         = $clog2(MAX_WIDTH + 1),
   parameter int EH         = $clog2(MAX_HEIGHT + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   load_go,
   input  logic                   first_pixel,
   input  logic [PIXEL_W-1:0]     pixel,
   output logic                   load_wr,
   output logic [ROW_W+COL_W-1:0] wr_addr,
   output logic [ROW_W+COL_W-1:0] above_addr,
   output logic                   above_zero,
   output logic [RSUM_W-1:0]      rsum_new,
   output logic                   done,
   output logic [EW-1:0]          eff_w,
   output logic [EH-1:0]          eff_h
);

   localparam int WX = (EW > IMG_W_W) ? EW : IMG_W_W;
   localparam int HX = (EH > IMG_H_W) ? EH : IMG_H_W;

   logic [IMG_W_W-1:0] width_ff,  width_in;
   logic [IMG_H_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]   col_ff,    col_in;
   logic [ROW_W-1:0]   row_ff,    row_in;
   logic [RSUM_W-1:0]  rsum_ff,   rsum_in;
   logic               done_ff,   done_in;

   logic [WX-1:0]      width_ext;
   logic [HX-1:0]      height_ext;
   logic [COL_W-1:0]   col0;
   logic [ROW_W-1:0]   row0;
   logic [RSUM_W-1:0]  rsum0;
   logic               done0;
   logic [EW-1:0]      col_nx;
   logic [EH-1:0]      row_nx;

   // clamp the size registers to 1..MAX
   always_comb begin
      width_ext  = WX'(width_ff);
      height_ext = HX'(height_ff);
      if (width_ext == '0) begin
         eff_w = EW'(1);
      end else if (width_ext > WX'(MAX_WIDTH)) begin
         eff_w = EW'(MAX_WIDTH);
      end else begin
         eff_w = EW'(width_ext);
      end
      if (height_ext == '0) begin
         eff_h = EH'(1);
      end else if (height_ext > HX'(MAX_HEIGHT)) begin
         eff_h = EH'(MAX_HEIGHT);
      end else begin
         eff_h = EH'(height_ext);
      end
   end

   // position of the pixel on the request port
   always_comb begin
      col0  = col_ff;
      row0  = row_ff;
      rsum0 = rsum_ff;
      done0 = done_ff;
      if (first_pixel) begin
         col0  = '0;
         row0  = '0;
         rsum0 = '0;
         done0 = 1'b0;
      end
      if (EW'(col0) >= eff_w || EH'(row0) >= eff_h) begin
         col0  = '0;
         row0  = '0;
         rsum0 = '0;
      end
      load_wr    = !done0;
      rsum_new   = rsum0 + RSUM_W'(pixel);
      above_zero = (row0 == '0);
      wr_addr    = {row0, col0};
      above_addr = {row0 - ROW_W'(1), col0};
      col_nx     = EW'(col0) + EW'(1);
      row_nx     = EH'(row0) + EH'(1);
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      rsum_in   = rsum_ff;
      done_in   = done_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_IMG_WIDTH:  width_in  = csr_wdata[IMG_W_W-1:0];
            CSR_IMG_HEIGHT: height_in = csr_wdata[IMG_H_W-1:0];
            default: ;
         endcase
         col_in  = '0;
         row_in  = '0;
         rsum_in = '0;
         done_in = 1'b0;
      end else if (load_go && load_wr) begin
         done_in = 1'b0;
         if (col_nx == eff_w) begin
            col_in  = '0;
            rsum_in = '0;
            if (row_nx == eff_h) begin
               row_in  = '0;
               done_in = 1'b1;
            end else begin
               row_in = ROW_W'(row_nx);
            end
         end else begin
            col_in  = COL_W'(col_nx);
            row_in  = row0;
            rsum_in = rsum_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMG_WIDTH_RST;
         height_ff <= IMG_HEIGHT_RST;
         col_ff    <= '0;
         row_ff    <= '0;
         rsum_ff   <= '0;
         done_ff   <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         rsum_ff   <= rsum_in;
         done_ff   <= done_in;
      end
   end

   assign done = done_ff;

endmodule

>>> hw/rtl/integral_image_rect_sum_core.sv
// ----------------------------------------------------------------------------
// integral_image_rect_sum_core
// Summed-area table builder with four-corner rectangle box-sum queries.
// ----------------------------------------------------------------------------
// Pixels (cmd load) arrive in raster order and each one writes the table
// entry running-row-sum + entry above; first_pixel restarts the build, and
// loads after the image is complete are dropped until the next first_pixel.
// A query (cmd 1) returns one item: the box sum with status ok, or sum 0 with
// status "out of bounds" or "image not complete". The table is held in two
// identical RAM copies, each with one write and one registered read port, so
// two entries can be read per cycle. A load reads the entry above on accept
// and writes the new entry in ST_LOAD_WR; a dropped load stays in ST_IDLE.
// A query reads two corners on accept and two in ST_QRY_RD2 (two corners
// per cycle); the next item is accepted in ST_QRY_FIN, the cycle that forms
// the sum, while the result port takes items. The table is not cleared
// after reset: a query only uses the sum once a complete image is written.
// ----------------------------------------------------------------------------
module integral_image_rect_sum_core import iirs_pkg::*; #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int AW    = ROW_W + COL_W;
   localparam int DEPTH = MAX_HEIGHT << COL_W;
   localparam int EW    = $clog2(MAX_WIDTH + 1);
   localparam int EH    = $clog2(MAX_HEIGHT + 1);
   localparam int QX    = (EW > EDGE_X_W) ? EW : EDGE_X_W;
   localparam int QY    = (EH > EDGE_Y_W) ? EH : EDGE_Y_W;

   state_type state_ff, state_in;

   // scan interface
   logic              load_wr;
   logic [AW-1:0]     scan_wr_addr;
   logic [AW-1:0]     scan_above_addr;
   logic              scan_above_zero;
   logic [RSUM_W-1:0] scan_rsum_new;
   logic              done;
   logic [EW-1:0]     eff_w;
   logic [EH-1:0]     eff_h;

   // handshake
   logic              out_free;
   logic              req_accept;
   logic              load_go;
   logic              query_go;

   // table ports
   logic              mem_wr_en;
   logic [SUM_W-1:0]  mem_wr_data;
   logic              mem_rd_en;
   logic [AW-1:0]     rd_addr_a;
   logic [AW-1:0]     rd_addr_b;
   logic [SUM_W-1:0]  rd_data_a;
   logic [SUM_W-1:0]  rd_data_b;

   // pending load
   logic [AW-1:0]     wr_addr_ff;
   logic [RSUM_W-1:0] wr_rsum_ff;
   logic              wr_above_zero_ff;

   // query decode
   logic [QX-1:0]       edge_x;
   logic [QY-1:0]       edge_y;
   logic [COL_W-1:0]    col_r;
   logic [COL_W-1:0]    col_l;
   logic [ROW_W-1:0]    row_b;
   logic [ROW_W-1:0]    row_t;
   logic [STATUS_W-1:0] q_status;

   // pending query
   logic [AW-1:0]       qb_addr_ff;
   logic [AW-1:0]       qc_addr_ff;
   logic                za_ff;
   logic                zb_ff;
   logic                zc_ff;
   logic [STATUS_W-1:0] q_status_ff;
   logic [SUM_W-1:0]    s1_ff, s1_in;
   logic [SUM_W-1:0]    box_sum;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff,  rsp_data_in;

   iirs_scan #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .load_go     (load_go),
      .first_pixel (req_data.first_pixel),
      .pixel       (req_data.pixel),
      .load_wr     (load_wr),
      .wr_addr     (scan_wr_addr),
      .above_addr  (scan_above_addr),
      .above_zero  (scan_above_zero),
      .rsum_new    (scan_rsum_new),
      .done        (done),
      .eff_w       (eff_w),
      .eff_h       (eff_h)
   );

   // ---------------------------------------------------------------------
   // Handshake: take a new item when idle, or in the final query cycle
   // once the result register can take the finished result.
   // ---------------------------------------------------------------------
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == ST_IDLE) ||
                         (state_ff == ST_QRY_FIN && out_free));
   assign req_accept = req_valid && !req_stall;
   assign load_go    = req_accept && (req_data.cmd == CMD_LOAD);
   assign query_go   = req_accept && (req_data.cmd == CMD_QUERY);

   // ---------------------------------------------------------------------
   // Query decode: status and the four corner addresses. The corners are
   // D (x1-1,y1-1), A (x-1,y-1), B (x1-1,y-1), C (x-1,y1-1); a corner that
   // falls left of or above the image counts as zero.
   // ---------------------------------------------------------------------
   always_comb begin
      edge_x = QX'(req_data.rect_x) + QX'(req_data.rect_w);
      edge_y = QY'(req_data.rect_y) + QY'(req_data.rect_h);
      col_r  = COL_W'(edge_x - QX'(1));
      col_l  = COL_W'(QX'(req_data.rect_x) - QX'(1));
      row_b  = ROW_W'(edge_y - QY'(1));
      row_t  = ROW_W'(QY'(req_data.rect_y) - QY'(1));
      if (!done) begin
         q_status = STATUS_NOT_READY;
      end else if (req_data.rect_w == '0 || req_data.rect_h == '0 ||
                   edge_x > QX'(eff_w) || edge_y > QY'(eff_h)) begin
         q_status = STATUS_BOUNDS;
      end else begin
         q_status = STATUS_OK;
      end
   end

   // ---------------------------------------------------------------------
   // Table read ports: first read on accept (entry above for a load,
   // corners D and A for a query), second query read in ST_QRY_RD2.
   // Hold the read data while a finished query waits on the result port.
   // ---------------------------------------------------------------------
   always_comb begin
      mem_rd_en = req_accept || (state_ff == ST_QRY_RD2);
      rd_addr_a = qb_addr_ff;
      rd_addr_b = qc_addr_ff;
      if (req_accept) begin
         if (req_data.cmd == CMD_LOAD) begin
            rd_addr_a = scan_above_addr;
            rd_addr_b = scan_above_addr;
         end else begin
            rd_addr_a = {row_b, col_r};
            rd_addr_b = {row_t, col_l};
         end
      end
   end

   // write back the new entry in ST_LOAD_WR, in the cycle after the read of the entry above
   assign mem_wr_en   = (state_ff == ST_LOAD_WR);
   assign mem_wr_data = SUM_W'(wr_rsum_ff) + (wr_above_zero_ff ? '0 : rd_data_a);

   iirs_ram #(
      .WIDTH (SUM_W),
      .DEPTH (DEPTH)
   ) u_table_a (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wr_addr_ff),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_addr_a),
      .rd_data (rd_data_a)
   );

   iirs_ram #(
      .WIDTH (SUM_W),
      .DEPTH (DEPTH)
   ) u_table_b (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wr_addr_ff),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_addr_b),
      .rd_data (rd_data_b)
   );

   // ---------------------------------------------------------------------
   // Sum: D + A in ST_QRY_RD2, then subtract B and C in ST_QRY_FIN.
   // ---------------------------------------------------------------------
   assign s1_in   = rd_data_a + (za_ff ? '0 : rd_data_b);
   assign box_sum = s1_ff - (zb_ff ? '0 : rd_data_a) - (zc_ff ? '0 : rd_data_b);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE, ST_QRY_FIN: begin
            if (req_accept) begin
               if (req_data.cmd == CMD_QUERY) begin
                  state_in = ST_QRY_RD2;
               end else if (load_wr) begin
                  state_in = ST_LOAD_WR;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (state_ff == ST_QRY_FIN && out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_LOAD_WR: state_in = ST_IDLE;
         ST_QRY_RD2: state_in = ST_QRY_FIN;
         default:    state_in = ST_IDLE;
      endcase
   end

   // result register: load on query completion, drain when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == ST_QRY_FIN && out_free) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.status   = q_status_ff;
         rsp_data_in.rect_sum = (q_status_ff == STATUS_OK) ? box_sum : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (load_go) begin
         wr_addr_ff       <= scan_wr_addr;
         wr_rsum_ff       <= scan_rsum_new;
         wr_above_zero_ff <= scan_above_zero;
      end
      if (query_go) begin
         qb_addr_ff  <= {row_t, col_r};
         qc_addr_ff  <= {row_b, col_l};
         za_ff       <= (req_data.rect_x == '0) || (req_data.rect_y == '0);
         zb_ff       <= (req_data.rect_y == '0);
         zc_ff       <= (req_data.rect_x == '0);
         q_status_ff <= q_status;
      end
      if (state_ff == ST_QRY_RD2) begin
         s1_ff <= s1_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_QRY_FIN))
      else $error("result item raised outside query completion");

   a_error_zero_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |-> rsp_data.rect_sum == '0)
      else $error("error result carries a nonzero sum");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STATUS_OK ||
                     rsp_data.status == STATUS_BOUNDS ||
                     rsp_data.status == STATUS_NOT_READY))
      else $error("result status outside defined codes");

   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD_WR |-> $past(load_go))
      else $error("table write without an accepted load");

endmodule
